// File: rtl/core/svpb_pkg.sv
// shared constants, command and op codes, and queue types for the voxel position buffer
// no dependencies

package svpb_pkg;

  // store geometry and sprite limits
  localparam int MAX_PIXELS    = 131072;
  localparam int SPRITE_WIDTH  = 32;
  localparam int SPRITE_HEIGHT = 40;
  localparam int ADDR_W        = $clog2(MAX_PIXELS);

  // field widths
  localparam int FW_W    = 10;
  localparam int FH_W    = 9;
  localparam int WXY_W   = 14;
  localparam int WZ_W    = 10;
  localparam int ENTRY_W = 2 * WXY_W + WZ_W;
  localparam int PROD_W  = FW_W + FH_W + 1;

  // tile to voxel scale
  localparam int TILE_XY_SCALE = 16;
  localparam int TILE_Z_SCALE  = 24;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PLOT  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // register index of the config port
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // what the back end does with a queued op
  typedef enum logic [1:0] {
    OP_PASS,
    OP_WRITE,
    OP_READ,
    OP_CLEAR
  } svpb_kind_t;

  typedef struct packed {
    svpb_kind_t         kind;
    logic [ADDR_W-1:0]  addr;
    logic               wrote;
    logic               on_screen;
    logic [WXY_W-1:0]   wx;
    logic [WXY_W-1:0]   wy;
    logic [WZ_W-1:0]    wz;
  } svpb_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } svpb_qstat_t;

endpackage

// File: rtl/core/svpb_front.sv
// front end: takes commands, computes screen and world positions, classifies into ops
// depends on svpb_pkg

module svpb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           cmd,
  input  logic signed [11:0]   dest_x,
  input  logic signed [11:0]   dest_y,
  input  logic [4:0]           sprite_col,
  input  logic [5:0]           sprite_row,
  input  logic [7:0]           sprite_color,
  input  logic signed [7:0]    offset_vox_x,
  input  logic signed [7:0]    offset_vox_y,
  input  logic signed [7:0]    offset_vox_z,
  input  logic [7:0]           tile_pos_x,
  input  logic [7:0]           tile_pos_y,
  input  logic [3:0]           tile_level,
  input  logic [9:0]           frame_width,
  input  logic [8:0]           frame_height,
  input  svpb_pkg::svpb_qstat_t q_stat,
  output logic                 q_push,
  output svpb_pkg::svpb_op_t   q_op
);
  import svpb_pkg::*;

  // stage 1: captured command
  logic        s1_valid;
  logic [1:0]  s1_cmd;
  logic [11:0] s1_dx, s1_dy;
  logic [4:0]  s1_col;
  logic [5:0]  s1_row;
  logic [7:0]  s1_color;
  logic [7:0]  s1_ox, s1_oy, s1_oz;
  logic [7:0]  s1_tx, s1_ty;
  logic [3:0]  s1_tz;

  // stage 2: classified command
  logic             s2_valid;
  logic [1:0]       s2_cmd;
  logic             s2_inside;
  logic             s2_want;
  logic [FW_W-1:0]  s2_sx;
  logic [FH_W-1:0]  s2_sy;
  logic [WXY_W-1:0] s2_wx, s2_wy;
  logic [WZ_W-1:0]  s2_wz;

  logic             accept, s1_move, s2_free;
  logic [4:0]       add_col;
  logic [5:0]       add_row;
  logic [12:0]      sx, sy;
  logic             on_screen, want;
  logic [WXY_W-1:0] wx, wy;
  logic [WZ_W-1:0]  wz;
  logic [8:0]       tz_scaled;
  logic [PROD_W-1:0] prod, addr_full;
  logic             in_range;

  assign q_push  = s2_valid && !q_stat.full;
  assign s2_free = !s2_valid || q_push;
  assign s1_move = s1_valid && s2_free;
  assign busy    = s1_valid && !s2_free;
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (q_push) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd   <= cmd;
      s1_dx    <= dest_x;
      s1_dy    <= dest_y;
      s1_col   <= sprite_col;
      s1_row   <= sprite_row;
      s1_color <= sprite_color;
      s1_ox    <= offset_vox_x;
      s1_oy    <= offset_vox_y;
      s1_oz    <= offset_vox_z;
      s1_tx    <= tile_pos_x;
      s1_ty    <= tile_pos_y;
      s1_tz    <= tile_level;
    end
  end

  // screen position, clip test and world position
  always_comb begin
    add_col   = (s1_cmd == CMD_PLOT) ? s1_col : '0;
    add_row   = (s1_cmd == CMD_PLOT) ? s1_row : '0;
    sx        = {s1_dx[11], s1_dx} + {8'b0, add_col};
    sy        = {s1_dy[11], s1_dy} + {7'b0, add_row};
    on_screen = !sx[12] && !sy[12] && (sx < {3'b0, frame_width})
                && (sy < {4'b0, frame_height});
    wx        = WXY_W'(s1_tx * TILE_XY_SCALE) + {{(WXY_W-8){s1_ox[7]}}, s1_ox};
    wy        = WXY_W'(s1_ty * TILE_XY_SCALE) + {{(WXY_W-8){s1_oy[7]}}, s1_oy};
    tz_scaled = 9'(s1_tz * TILE_Z_SCALE);
    wz        = {1'b0, tz_scaled} + {{(WZ_W-8){s1_oz[7]}}, s1_oz};
    want      = on_screen && (s1_color != 8'd0)
                && ({1'b0, s1_col} < 6'(SPRITE_WIDTH))
                && ({1'b0, s1_row} < 7'(SPRITE_HEIGHT)) && !wz[WZ_W-1];
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_cmd <= s1_cmd;
      s2_sx  <= sx[FW_W-1:0];
      s2_sy  <= sy[FH_W-1:0];
      unique case (s1_cmd)
        CMD_PLOT: begin
          s2_inside <= on_screen;
          s2_want   <= want;
          s2_wx     <= wx;
          s2_wy     <= wy;
          s2_wz     <= wz;
        end
        CMD_READ: begin
          s2_inside <= on_screen;
          s2_want   <= on_screen;
          s2_wx     <= '1;
          s2_wy     <= '1;
          s2_wz     <= '1;
        end
        CMD_CLEAR: begin
          s2_inside <= 1'b0;
          s2_want   <= 1'b0;
          s2_wx     <= '1;
          s2_wy     <= '1;
          s2_wz     <= '1;
        end
        default: begin
          s2_inside <= 1'b0;
          s2_want   <= 1'b0;
          s2_wx     <= '0;
          s2_wy     <= '0;
          s2_wz     <= '0;
        end
      endcase
    end
  end

  // row address and store range check
  always_comb begin
    prod      = PROD_W'(s2_sy) * PROD_W'(frame_width);
    addr_full = prod + PROD_W'(s2_sx);
    in_range  = 33'(addr_full) < 33'(MAX_PIXELS);
    q_op.addr      = addr_full[ADDR_W-1:0];
    q_op.on_screen = s2_inside;
    q_op.wx        = s2_wx;
    q_op.wy        = s2_wy;
    q_op.wz        = s2_wz;
    unique case (s2_cmd)
      CMD_CLEAR: begin
        q_op.kind  = OP_CLEAR;
        q_op.wrote = 1'b0;
      end
      CMD_PLOT: begin
        q_op.kind  = (s2_want && in_range) ? OP_WRITE : OP_PASS;
        q_op.wrote = s2_want && in_range;
      end
      CMD_READ: begin
        q_op.kind  = (s2_want && in_range) ? OP_READ : OP_PASS;
        q_op.wrote = 1'b0;
      end
      default: begin
        q_op.kind  = OP_PASS;
        q_op.wrote = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/svpb_queue.sv
// two-entry op queue between front and back end
// depends on svpb_pkg

module svpb_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  svpb_pkg::svpb_op_t    push_op,
  input  logic                  pop,
  output svpb_pkg::svpb_op_t    head_op,
  output svpb_pkg::svpb_qstat_t stat
);
  import svpb_pkg::*;

  svpb_op_t   entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign head_op    = entries[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

// File: rtl/core/svpb_back.sv
// back end: owns the voxel store, runs writes, reads and the clear sweep, drives results
// depends on svpb_pkg

module svpb_back (
  input  logic                  clk,
  input  logic                  rst,
  input  svpb_pkg::svpb_qstat_t q_stat,
  input  svpb_pkg::svpb_op_t    q_op,
  output logic                  q_pop,
  output logic                  done,
  output logic                  wrote,
  output logic                  inside_res,
  output logic signed [13:0]    world_x,
  output logic signed [13:0]    world_y,
  output logic signed [9:0]     world_z
);
  import svpb_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]         state;
  logic [ADDR_W-1:0]  clr_addr;
  logic               clr_last;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic [ENTRY_W-1:0] mem_wdata, rd_data;
  logic [ENTRY_W-1:0] mem [MAX_PIXELS];

  assign q_pop     = (state == ST_IDLE) && !q_stat.empty;
  assign clr_last  = (clr_addr == ADDR_W'(MAX_PIXELS - 1));
  assign mem_we    = (state == ST_CLEAR) || (q_pop && q_op.kind == OP_WRITE);
  assign mem_re    = q_pop && (q_op.kind == OP_READ);
  assign mem_addr  = (state == ST_CLEAR) ? clr_addr : q_op.addr;
  assign mem_wdata = (state == ST_CLEAR) ? '1 : {q_op.wx, q_op.wy, q_op.wz};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_op.kind) inside
              OP_CLEAR: begin
                state    <= ST_CLEAR;
                clr_addr <= '0;
              end
              OP_READ: begin
                state <= ST_READ;
              end
              OP_PASS, OP_WRITE: begin
                done <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_last) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_READ: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_pop) begin
      wrote      <= q_op.wrote;
      inside_res <= q_op.on_screen;
      world_x    <= q_op.wx;
      world_y    <= q_op.wy;
      world_z    <= q_op.wz;
    end else if (state == ST_CLEAR && clr_last) begin
      wrote      <= 1'b0;
      inside_res <= 1'b0;
      world_x    <= '1;
      world_y    <= '1;
      world_z    <= '1;
    end else if (state == ST_READ) begin
      wrote      <= 1'b0;
      inside_res <= 1'b1;
      world_x    <= rd_data[ENTRY_W-1 -: WXY_W];
      world_y    <= rd_data[WZ_W +: WXY_W];
      world_z    <= rd_data[WZ_W-1:0];
    end
  end

endmodule

// File: rtl/core/sprite_voxel_position_buffer.sv
// top level of the voxel position buffer: config registers, front end, queue, back end
// depends on svpb_pkg, svpb_front, svpb_queue, svpb_back
//
// usage
//   command channel: a word is taken at a rising edge with start high and busy low.
//   cmd 0 clears the whole store to (-1,-1,-1), cmd 1 plots one sprite pixel,
//   cmd 2 reads one pixel entry back, cmd 3 does nothing and answers all zero.
//   result channel: every command gives one result word, shown for exactly one
//   cycle with done high; the receiver cannot hold it off, results leave in order.
//   result path: capture stage, classify stage, queue, then the back end; a plot or
//   no-op shows done as the back end takes it, a read passes ST_READ for the store
//   data first, and a clear sweeps the store one entry a cycle through the single
//   memory port and shows done after the last entry.
//   a read holds the back end in ST_READ, a clear for the whole sweep; the front end and
//   a two-word queue hold up to four commands while the back end is busy, then busy rises.
//   config: apb-style port, frame_width at byte address 0, frame_height at 4; write
//   only while no command is in flight. pready is tied high.
//   reset: synchronous rst empties the pipeline and queue and loads width 320 and
//   height 200; store contents are undefined until the first clear.
//   entry address is y * frame_width + x; a pixel past the store is never written
//   and reads back as (-1,-1,-1).

module sprite_voxel_position_buffer (
  input  logic                clk,
  input  logic                rst,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          cmd,
  input  logic signed [11:0]  dest_x,
  input  logic signed [11:0]  dest_y,
  input  logic [4:0]          sprite_col,
  input  logic [5:0]          sprite_row,
  input  logic [7:0]          sprite_color,
  input  logic signed [7:0]   offset_vox_x,
  input  logic signed [7:0]   offset_vox_y,
  input  logic signed [7:0]   offset_vox_z,
  input  logic [7:0]          tile_pos_x,
  input  logic [7:0]          tile_pos_y,
  input  logic [3:0]          tile_level,
  // result channel
  output logic                done,
  output logic                wrote,
  output logic                inside_res,
  output logic signed [13:0]  world_x,
  output logic signed [13:0]  world_y,
  output logic signed [9:0]   world_z,
  // config port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import svpb_pkg::*;

  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic            cfg_wr;

  svpb_qstat_t q_stat;
  svpb_op_t    push_op, head_op;
  logic        q_push, q_pop;

  // config registers, decoded on the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FW_W'(320);
      frame_height <= FH_W'(200);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(frame_width);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // front end: capture, position math, classification
  svpb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .dest_x       (dest_x),
    .dest_y       (dest_y),
    .sprite_col   (sprite_col),
    .sprite_row   (sprite_row),
    .sprite_color (sprite_color),
    .offset_vox_x (offset_vox_x),
    .offset_vox_y (offset_vox_y),
    .offset_vox_z (offset_vox_z),
    .tile_pos_x   (tile_pos_x),
    .tile_pos_y   (tile_pos_y),
    .tile_level   (tile_level),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_op         (push_op)
  );

  // decouples the front end from long clears in the back end
  svpb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head_op (head_op),
    .stat    (q_stat)
  );

  // back end: store access and result words
  svpb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .q_op       (head_op),
    .q_pop      (q_pop),
    .done       (done),
    .wrote      (wrote),
    .inside_res (inside_res),
    .world_x    (world_x),
    .world_y    (world_y),
    .world_z    (world_z)
  );

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !q_push)
    else $error("push into full op queue");

  // a stored position always comes from a pixel inside the frame
  a_wrote_inside: assert property (@(posedge clk) disable iff (rst)
    (done && wrote) |-> inside_res)
    else $error("write reported for a clipped pixel");

  // stored positions never have negative z
  a_wrote_z: assert property (@(posedge clk) disable iff (rst)
    (done && wrote) |-> !world_z[9])
    else $error("write reported with negative z");

  // nothing pops while the queue is empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !q_pop)
    else $error("pop from empty op queue");

endmodule

// File: tb/tb_sprite_voxel_position_buffer.sv
// self-checking testbench for the sprite voxel position buffer: command words in, result words
// checked in order against an in-bench prediction of the per-pixel voxel store
// depends on svpb_pkg and sprite_voxel_position_buffer
`timescale 1ns / 1ps

module tb_sprite_voxel_position_buffer;
  import svpb_pkg::*;

  // cmd 3 has no name in the package: it does nothing and answers all zero
  localparam logic [1:0] CMD_NOP = 2'd3;

  // tile to voxel scale
  localparam int XY_SCALE = 16;
  localparam int Z_SCALE  = 24;

  // one clear walks the whole store, so the limit is dominated by that sweep
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int END_SLACK    = 16;
  localparam int MAX_REPORTS  = 10;

  // one command word as the sender sees it
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [11:0] dest_x;
    logic signed [11:0] dest_y;
    logic [4:0]         sprite_col;
    logic [5:0]         sprite_row;
    logic [7:0]         sprite_color;
    logic signed [7:0]  offset_vox_x;
    logic signed [7:0]  offset_vox_y;
    logic signed [7:0]  offset_vox_z;
    logic [7:0]         tile_pos_x;
    logic [7:0]         tile_pos_y;
    logic [3:0]         tile_level;
  } pixel_word_t;

  typedef struct packed {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic signed [9:0]  z;
  } voxel_pos_t;

  typedef struct packed {
    logic       wrote;
    logic       on_screen;
    voxel_pos_t pos;
  } voxel_result_t;

  // all ones is (-1,-1,-1): what a cleared or unreachable entry holds
  localparam voxel_pos_t EMPTY_POS = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // command channel
  logic               start        = 1'b0;
  logic               busy;
  logic [1:0]         cmd          = CMD_NOP;
  logic signed [11:0] dest_x       = '0;
  logic signed [11:0] dest_y       = '0;
  logic [4:0]         sprite_col   = '0;
  logic [5:0]         sprite_row   = '0;
  logic [7:0]         sprite_color = '0;
  logic signed [7:0]  offset_vox_x = '0;
  logic signed [7:0]  offset_vox_y = '0;
  logic signed [7:0]  offset_vox_z = '0;
  logic [7:0]         tile_pos_x   = '0;
  logic [7:0]         tile_pos_y   = '0;
  logic [3:0]         tile_level   = '0;

  // result channel
  logic               done;
  logic               wrote;
  logic               inside_res;
  logic signed [13:0] world_x;
  logic signed [13:0] world_y;
  logic signed [9:0]  world_z;

  // config port
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the block: frame registers and the voxel store
  // entries missing from the map hold (-1,-1,-1), which is only true once a clear went by,
  // so no read is sent before the first clear
  int         frame_w = 320;
  int         frame_h = 200;
  voxel_pos_t voxel_shadow [int];

  // result words still owed by the block, oldest first
  voxel_result_t expected_results [$];

  // screen pixels recently plotted in the current frame setting, for reads that hit
  int recent_x [$];
  int recent_y [$];

  bit          sender_idles = 1'b1;
  int          bad_results  = 0;
  int unsigned cycle_count  = 0;

  sprite_voxel_position_buffer u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .dest_x       (dest_x),
    .dest_y       (dest_y),
    .sprite_col   (sprite_col),
    .sprite_row   (sprite_row),
    .sprite_color (sprite_color),
    .offset_vox_x (offset_vox_x),
    .offset_vox_y (offset_vox_y),
    .offset_vox_z (offset_vox_z),
    .tile_pos_x   (tile_pos_x),
    .tile_pos_y   (tile_pos_y),
    .tile_level   (tile_level),
    .done         (done),
    .wrote        (wrote),
    .inside_res   (inside_res),
    .world_x      (world_x),
    .world_y      (world_y),
    .world_z      (world_z),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[sprite_voxel_position_buffer] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic bit pixel_in_frame(input int x, input int y);
    return x >= 0 && y >= 0 && x < frame_w && y < frame_h;
  endfunction

  // works out the result word of one command and applies its effect to the shadow store
  function automatic voxel_result_t predict_voxel_result(input pixel_word_t w);
    voxel_result_t r;
    voxel_pos_t    p;
    int            sx, sy, px, py, pz, addr;
    r = '0;
    case (w.cmd)
      CMD_CLEAR: begin
        voxel_shadow.delete();
        r.pos = EMPTY_POS;
      end
      CMD_PLOT: begin
        sx = int'(w.dest_x) + int'(w.sprite_col);
        sy = int'(w.dest_y) + int'(w.sprite_row);
        px = int'(w.tile_pos_x) * XY_SCALE + int'(w.offset_vox_x);
        py = int'(w.tile_pos_y) * XY_SCALE + int'(w.offset_vox_y);
        pz = int'(w.tile_level) * Z_SCALE + int'(w.offset_vox_z);
        p.x = px[13:0];
        p.y = py[13:0];
        p.z = pz[9:0];
        // world fields carry the computed position even when nothing is stored
        r.pos = p;
        r.on_screen = pixel_in_frame(sx, sy);
        if (r.on_screen && w.sprite_color != 0 && int'(w.sprite_col) < SPRITE_WIDTH &&
            int'(w.sprite_row) < SPRITE_HEIGHT && pz >= 0) begin
          addr = sy * frame_w + sx;
          // only a frame of more than MAX_PIXELS pixels can point past the store
          if (addr < MAX_PIXELS) begin
            voxel_shadow[addr] = p;
            r.wrote = 1'b1;
          end
        end
      end
      CMD_READ: begin
        r.on_screen = pixel_in_frame(int'(w.dest_x), int'(w.dest_y));
        r.pos = EMPTY_POS;
        if (r.on_screen) begin
          addr = int'(w.dest_y) * frame_w + int'(w.dest_x);
          if (addr < MAX_PIXELS && voxel_shadow.exists(addr)) r.pos = voxel_shadow[addr];
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking: every done cycle must match the oldest owed word
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    voxel_result_t got, want;
    if (!rst && done === 1'b1) begin
      got = {wrote, inside_res, world_x, world_y, world_z};
      if (expected_results.size() == 0) begin
        bad_results++;
        if (bad_results <= MAX_REPORTS)
          $display("t=%0t stray result word wrote=%0b inside=%0b pos=(%0d,%0d,%0d)",
                   $time, got.wrote, got.on_screen, got.pos.x, got.pos.y, got.pos.z);
      end else begin
        want = expected_results.pop_front();
        if (got.wrote !== want.wrote || got.on_screen !== want.on_screen ||
            got.pos.x !== want.pos.x || got.pos.y !== want.pos.y ||
            got.pos.z !== want.pos.z) begin
          bad_results++;
          if (bad_results <= MAX_REPORTS)
            $display("t=%0t result mismatch: want wrote=%0b inside=%0b pos=(%0d,%0d,%0d)",
                     $time, want.wrote, want.on_screen, want.pos.x, want.pos.y, want.pos.z,
                     " got wrote=%0b inside=%0b pos=(%0d,%0d,%0d)",
                     got.wrote, got.on_screen, got.pos.x, got.pos.y, got.pos.z);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plumbing
  // ---------------------------------------------------------------------------

  function automatic pixel_word_t random_word();
    logic [95:0] bits;
    pixel_word_t w;
    bits = {$urandom, $urandom, $urandom};
    w = bits[$bits(pixel_word_t)-1:0];
    w.cmd = CMD_NOP;
    return w;
  endfunction

  // presents one word, holds it until taken, and books its expected result;
  // start stays high on return so back-to-back words see no gap
  task automatic send_word(input pixel_word_t w);
    while (sender_idles && $urandom_range(99) < 24) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    cmd          <= w.cmd;
    dest_x       <= w.dest_x;
    dest_y       <= w.dest_y;
    sprite_col   <= w.sprite_col;
    sprite_row   <= w.sprite_row;
    sprite_color <= w.sprite_color;
    offset_vox_x <= w.offset_vox_x;
    offset_vox_y <= w.offset_vox_y;
    offset_vox_z <= w.offset_vox_z;
    tile_pos_x   <= w.tile_pos_x;
    tile_pos_y   <= w.tile_pos_y;
    tile_level   <= w.tile_level;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(predict_voxel_result(w));
  endtask

  task automatic send_command(input logic [1:0] code);
    pixel_word_t w;
    w = random_word();
    w.cmd = code;
    send_word(w);
  endtask

  task automatic send_plot(input int dx, input int dy, input int col, input int row,
                           input int color, input int ox, input int oy, input int oz,
                           input int tx, input int ty, input int tl);
    pixel_word_t w;
    w = random_word();
    w.cmd          = CMD_PLOT;
    w.dest_x       = 12'(dx);
    w.dest_y       = 12'(dy);
    w.sprite_col   = 5'(col);
    w.sprite_row   = 6'(row);
    w.sprite_color = 8'(color);
    w.offset_vox_x = 8'(ox);
    w.offset_vox_y = 8'(oy);
    w.offset_vox_z = 8'(oz);
    w.tile_pos_x   = 8'(tx);
    w.tile_pos_y   = 8'(ty);
    w.tile_level   = 4'(tl);
    send_word(w);
  endtask

  // sprite fields stay random: a read must ignore them
  task automatic send_read(input int x, input int y);
    pixel_word_t w;
    w = random_word();
    w.cmd    = CMD_READ;
    w.dest_x = 12'(x);
    w.dest_y = 12'(y);
    send_word(w);
  endtask

  // stops sending and waits for every owed word, then a further margin
  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup then access; the register is taken at the access edge since pready is tied high.
  // psel is left up so a second write follows without a gap
  task automatic write_frame_reg(input logic idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) frame_w = value & 'h3FF;
    else frame_h = value & 'h1FF;
  endtask

  // registers only change with nothing in flight
  task automatic set_frame(input int fw, input int fh);
    drain_results();
    write_frame_reg(REG_FRAME_WIDTH, fw);
    write_frame_reg(REG_FRAME_HEIGHT, fh);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    recent_x.delete();
    recent_y.delete();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // a plot before any clear, then the clear must wipe it
  task automatic test_clear_store();
    send_plot(0, 0, 0, 0, 9, 5, 5, 5, 1, 1, 1);
    send_command(CMD_CLEAR);
    send_read(0, 0);
  endtask

  // field extremes, skip cases and clipping at the reset frame of 320 x 200
  task automatic test_plot_edges();
    // largest position at the top-left pixel
    send_plot(0, 0, 0, 0, 255, 127, 127, 127, 255, 255, 15);
    send_read(0, 0);
    // bottom-right pixel through the last sprite column and row, smallest x/y, z exactly 0
    send_plot(288, 160, 31, 39, 1, -128, -128, 0, 0, 0, 0);
    send_read(319, 199);
    // transparent pixel: inside but not stored
    send_plot(5, 5, 0, 0, 0, 1, 2, 3, 4, 5, 6);
    // world z below zero is not stored
    send_plot(6, 5, 0, 0, 7, 1, 2, -1, 4, 5, 0);
    // row past the sprite height lands on screen row 13 but is not stored
    send_plot(7, -50, 0, 63, 7, 1, 2, 3, 4, 5, 6);
    send_read(5, 5);
    send_read(6, 5);
    send_read(7, 13);
    // clipped on every side
    send_plot(-2048, -2048, 0, 0, 7, 0, 0, 0, 1, 1, 1);
    send_plot(2047, 2047, 31, 63, 7, 0, 0, 0, 1, 1, 1);
    send_plot(-32, 3, 31, 0, 7, 0, 0, 0, 1, 1, 1);
    send_read(-1, 0);
    send_read(320, 0);
    send_read(0, 200);
    send_read(2047, -2048);
    send_command(CMD_NOP);
  endtask

  // largest, smallest and empty frames, and a width that points past the store
  task automatic test_frame_extremes();
    set_frame(512, 256);
    send_plot(480, 216, 31, 39, 200, -1, -1, -1, 3, 3, 3);
    send_read(511, 255);
    set_frame(1, 1);
    send_plot(0, 0, 0, 0, 3, 10, 20, 30, 2, 2, 2);
    send_read(0, 0);
    send_read(1, 0);
    // zero width and height: nothing is inside
    set_frame(0, 0);
    send_plot(0, 0, 0, 0, 3, 10, 20, 30, 2, 2, 2);
    send_read(0, 0);
    // 200 * 1023 + 1000 is past the store: not written, reads back empty
    set_frame(1023, 511);
    send_plot(1000, 200, 0, 0, 3, 11, 22, 33, 9, 9, 9);
    send_read(1000, 200);
    send_plot(1000, 100, 0, 0, 3, 11, 22, 33, 9, 9, 9);
    send_read(1000, 100);
  endtask

  // mostly well-formed plots and reads that hit them, some raw noise words
  task automatic run_traffic_phase(input int fw, input int fh, input int count,
                                   input bit idles, input bit pause_mid);
    pixel_word_t w;
    int sx, sy, pick, k;
    set_frame(fw, fh);
    sender_idles = idles;
    for (int n = 0; n < count; n++) begin
      // hold off until the block has caught up completely
      if (pause_mid && n == count / 2) drain_results();
      w = random_word();
      pick = $urandom_range(99);
      if (pick < 55) begin
        w.cmd = CMD_PLOT;
        if ($urandom_range(9) == 0) sx = int'($urandom_range(fw + 79)) - 40;
        else sx = $urandom_range(fw - 1);
        if ($urandom_range(9) == 0) sy = int'($urandom_range(fh + 79)) - 40;
        else sy = $urandom_range(fh - 1);
        if ($urandom_range(9) == 0) w.sprite_row = 6'($urandom_range(63, SPRITE_HEIGHT));
        else w.sprite_row = 6'($urandom_range(SPRITE_HEIGHT - 1));
        w.dest_x = 12'(sx - int'(w.sprite_col));
        w.dest_y = 12'(sy - int'(w.sprite_row));
        if ($urandom_range(99) < 85) w.sprite_color = 8'($urandom_range(255, 1));
        else w.sprite_color = '0;
        if (pixel_in_frame(sx, sy)) begin
          recent_x.push_back(sx);
          recent_y.push_back(sy);
          if (recent_x.size() > 16) begin
            void'(recent_x.pop_front());
            void'(recent_y.pop_front());
          end
        end
      end else if (pick < 85) begin
        w.cmd = CMD_READ;
        if (recent_x.size() != 0 && $urandom_range(99) < 60) begin
          k = $urandom_range(recent_x.size() - 1);
          sx = recent_x[k];
          sy = recent_y[k];
        end else begin
          sx = $urandom_range(fw - 1);
          sy = $urandom_range(fh - 1);
        end
        w.dest_x = 12'(sx);
        w.dest_y = 12'(sy);
      end else begin
        // every field random; no clear here, one sweep costs the whole store
        w.cmd = 2'($urandom_range(CMD_PLOT, CMD_NOP));
      end
      send_word(w);
    end
    sender_idles = 1'b1;
  endtask

  task automatic test_random_traffic();
    run_traffic_phase($urandom_range(512, 1), $urandom_range(256, 1), 150, 1'b1, 1'b1);
    run_traffic_phase($urandom_range(16, 1), $urandom_range(16, 1), 150, 1'b1, 1'b0);
    // long stretch with the sender never idling
    run_traffic_phase(512, 256, 150, 1'b0, 1'b0);
    run_traffic_phase(320, 200, 150, 1'b1, 1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_clear_store();
    test_plot_edges();
    test_frame_extremes();
    test_random_traffic();
    drain_results();
    repeat (END_SLACK) @(posedge clk);
    if (bad_results == 0) $display("[sprite_voxel_position_buffer] OK");
    else $display("[sprite_voxel_position_buffer] ERROR");
    $finish;
  end

endmodule
